[src/dlr_pkg.sv]
// Shared types and constants for the DDA line rasterizer.
package dlr_pkg;

    localparam int COORD_W = 6;
    localparam int PAGE_W  = 3;
    localparam int BIT_W   = 3;

    localparam int DEF_SCREEN_WIDTH  = 64;
    localparam int DEF_SCREEN_HEIGHT = 48;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } line_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [PAGE_W-1:0]  page_index;
        logic [BIT_W-1:0]   bit_index;
        logic               last_pixel;
    } pixel_t;

    // Classified line: start point, delta magnitudes and signs, step count.
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] mag_x;
        logic [COORD_W-1:0] mag_y;
        logic               neg_x;
        logic               neg_y;
        logic [COORD_W-1:0] steps;
    } line_job_t;

endpackage

[src/dlr_front.sv]
// Front end: accepts line requests, forms deltas and step count, drops empty lines.
module dlr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dlr_pkg::line_req_t req,
    output logic               job_valid,
    input  logic               job_full,
    output dlr_pkg::line_job_t job
);
    import dlr_pkg::*;

    logic               job_valid_reg, job_valid_next;
    line_job_t          job_reg, job_next;
    logic               take;
    logic               ready;
    logic [COORD_W:0]   dx, dy;
    logic [COORD_W:0]   ax, ay;

    assign ready     = !job_valid_reg || !job_full;
    assign req_stall = !ready;
    assign take      = req_valid && ready;

    always_comb
    begin
        dx = {1'b0, req.end_x} - {1'b0, req.start_x};
        dy = {1'b0, req.end_y} - {1'b0, req.start_y};
        ax = dx[COORD_W] ? -dx : dx;
        ay = dy[COORD_W] ? -dy : dy;
        job_next.x0    = req.start_x;
        job_next.y0    = req.start_y;
        job_next.mag_x = ax[COORD_W-1:0];
        job_next.mag_y = ay[COORD_W-1:0];
        job_next.neg_x = dx[COORD_W];
        job_next.neg_y = dy[COORD_W];
        job_next.steps = (ax >= ay) ? ax[COORD_W-1:0] : ay[COORD_W-1:0];
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (take)
            job_valid_next = (job_next.steps != '0);
        else if (job_valid_reg && !job_full)
            job_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else
            job_valid_reg <= job_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[src/dlr_queue.sv]
// Short job queue between the front end and the stepper.
module dlr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dlr_pkg::line_job_t push_job,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output dlr_pkg::line_job_t pop_job
);
    import dlr_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    line_job_t       mem [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

[src/dlr_back.sv]
// Back end: increment division, DDA stepping, last-pixel lookahead and output register.
module dlr_back #(
    parameter int SCREEN_WIDTH  = dlr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dlr_pkg::DEF_SCREEN_HEIGHT,
    parameter int FRACTION_BITS = dlr_pkg::DEF_FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_avail,
    input  dlr_pkg::line_job_t job,
    output logic               job_pop,
    output logic               pix_valid,
    input  logic               pix_stall,
    output dlr_pkg::pixel_t    pix
);
    import dlr_pkg::*;

    localparam int DIV_N  = COORD_W + FRACTION_BITS;
    localparam int DIV_CW = $clog2(DIV_N + 1);
    localparam int ACC_W  = DIV_N + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_STEP  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [DIV_CW-1:0]   div_cnt_reg, div_cnt_next;
    logic [COORD_W-1:0]  step_cnt_reg, step_cnt_next;
    line_job_t           job_reg;

    // quotient shifts in from the bottom while the dividend shifts out the top
    logic [DIV_N-1:0]    dq_x_reg, dq_x_next, dq_y_reg, dq_y_next;
    logic [COORD_W-1:0]  rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [COORD_W:0]    rsh_x, rsh_y, rsub_x, rsub_y;
    logic                ge_x, ge_y;

    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [ACC_W-1:0] inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic signed [ACC_W-1:0] q_x, q_y;

    logic [COORD_W-1:0]  cand_x, cand_y;
    logic                cand_ok;

    logic                hold_valid_reg, hold_valid_next;
    logic [COORD_W-1:0]  hold_x_reg, hold_y_reg;
    logic                hold_load;

    logic                out_valid_reg, out_valid_next;
    pixel_t              out_reg;
    logic                out_free;
    logic                push;
    logic                push_last;
    logic                advance;

    assign out_free = !out_valid_reg || !pix_stall;
    assign job_pop  = (state_reg == ST_IDLE) && job_avail;

    // one restoring-division bit per cycle for both axes
    always_comb
    begin
        rsh_x  = {rem_x_reg, dq_x_reg[DIV_N-1]};
        rsh_y  = {rem_y_reg, dq_y_reg[DIV_N-1]};
        ge_x   = (rsh_x >= {1'b0, job_reg.steps});
        ge_y   = (rsh_y >= {1'b0, job_reg.steps});
        rsub_x = rsh_x - {1'b0, job_reg.steps};
        rsub_y = rsh_y - {1'b0, job_reg.steps};
    end

    always_comb
    begin
        q_x = $signed({1'b0, dq_x_reg});
        q_y = $signed({1'b0, dq_y_reg});
        if (job_reg.neg_x)
            q_x = -q_x;
        if (job_reg.neg_y)
            q_y = -q_y;
    end

    assign cand_x  = acc_x_reg[FRACTION_BITS +: COORD_W];
    assign cand_y  = acc_y_reg[FRACTION_BITS +: COORD_W];
    assign cand_ok = !acc_x_reg[ACC_W-1] && !acc_y_reg[ACC_W-1] &&
                     (int'(cand_x) < SCREEN_WIDTH) && (int'(cand_y) < SCREEN_HEIGHT);

    // a visible pixel pushes out the held one, so it can stall on the output
    assign advance = !(cand_ok && hold_valid_reg && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        div_cnt_next    = div_cnt_reg;
        step_cnt_next   = step_cnt_reg;
        dq_x_next       = dq_x_reg;
        dq_y_next       = dq_y_reg;
        rem_x_next      = rem_x_reg;
        rem_y_next      = rem_y_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        hold_valid_next = hold_valid_reg;
        hold_load       = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    dq_x_next    = {job.mag_x, {FRACTION_BITS{1'b0}}};
                    dq_y_next    = {job.mag_y, {FRACTION_BITS{1'b0}}};
                    rem_x_next   = '0;
                    rem_y_next   = '0;
                    div_cnt_next = DIV_CW'(DIV_N);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dq_x_next    = {dq_x_reg[DIV_N-2:0], ge_x};
                dq_y_next    = {dq_y_reg[DIV_N-2:0], ge_y};
                rem_x_next   = ge_x ? rsub_x[COORD_W-1:0] : rsh_x[COORD_W-1:0];
                rem_y_next   = ge_y ? rsub_y[COORD_W-1:0] : rsh_y[COORD_W-1:0];
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    dq_x_next     = dq_x_reg;
                    dq_y_next     = dq_y_reg;
                    rem_x_next    = rem_x_reg;
                    rem_y_next    = rem_y_reg;
                    div_cnt_next  = div_cnt_reg;
                    inc_x_next    = q_x;
                    inc_y_next    = q_y;
                    acc_x_next    = $signed({1'b0, job_reg.x0, 1'b1,
                                             {(FRACTION_BITS-1){1'b0}}});
                    acc_y_next    = $signed({1'b0, job_reg.y0, 1'b1,
                                             {(FRACTION_BITS-1){1'b0}}});
                    step_cnt_next = job_reg.steps;
                    state_next    = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (advance)
                begin
                    if (cand_ok)
                    begin
                        push            = hold_valid_reg;
                        hold_load       = 1'b1;
                        hold_valid_next = 1'b1;
                    end
                    acc_x_next    = acc_x_reg + inc_x_reg;
                    acc_y_next    = acc_y_reg + inc_y_reg;
                    step_cnt_next = step_cnt_reg - 1'b1;
                    if (step_cnt_reg == COORD_W'(1))
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_cnt_reg  <= div_cnt_next;
        step_cnt_reg <= step_cnt_next;
        dq_x_reg     <= dq_x_next;
        dq_y_reg     <= dq_y_next;
        rem_x_reg    <= rem_x_next;
        rem_y_reg    <= rem_y_next;
        acc_x_reg    <= acc_x_next;
        acc_y_reg    <= acc_y_next;
        inc_x_reg    <= inc_x_next;
        inc_y_reg    <= inc_y_next;
        if (job_pop)
            job_reg <= job;
        if (hold_load)
        begin
            hold_x_reg <= cand_x;
            hold_y_reg <= cand_y;
        end
        if (out_free && push)
        begin
            out_reg.pixel_x    <= hold_x_reg;
            out_reg.pixel_y    <= hold_y_reg;
            out_reg.page_index <= hold_y_reg[COORD_W-1:BIT_W];
            out_reg.bit_index  <= hold_y_reg[BIT_W-1:0];
            out_reg.last_pixel <= push_last;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

[src/dda_line_rasterizer_top.sv]
// Top level of the DDA line rasterizer.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | line_req_t: start_x, start_y, end_x, end_y
//  pix     | out       | pix_valid / pix_stall  | pixel_t: pixel_x, pixel_y, page, bit, last
//
// A line goes through the bit-serial increment divider, which divides by steps
// (steps = longer axis span, up to 63), then the stepper at one pixel step per
// cycle unless the output stalls. Zero-length lines are dropped in the front end.
// Reset clears the queue, the stepper state and the output valid flag.
// A stall on pix holds the stepper; the queue keeps taking requests until full.
module dda_line_rasterizer_top #(
    parameter int SCREEN_WIDTH  = dlr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dlr_pkg::DEF_SCREEN_HEIGHT,
    parameter int FRACTION_BITS = dlr_pkg::DEF_FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dlr_pkg::line_req_t req,
    output logic               pix_valid,
    input  logic               pix_stall,
    output dlr_pkg::pixel_t    pix
);
    import dlr_pkg::*;

    logic      front_valid;
    line_job_t front_job;
    logic      q_full;
    logic      q_not_empty;
    line_job_t q_job;
    logic      q_pop;

    dlr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (front_valid),
        .job_full  (q_full),
        .job       (front_job)
    );

    dlr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    dlr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_not_empty),
        .job       (q_job),
        .job_pop   (q_pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule

[src/dlr_checker.sv]
// Port-level checks for the DDA line rasterizer, bound to the top level.
module dlr_checker #(
    parameter int SCREEN_WIDTH  = dlr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dlr_pkg::DEF_SCREEN_HEIGHT
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input dlr_pkg::line_req_t req,
    input logic               pix_valid,
    input logic               pix_stall,
    input dlr_pkg::pixel_t    pix
);
    import dlr_pkg::*;

    // a stalled request transfer keeps its payload
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // a stalled transfer keeps its pixel
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix))
        else $error("pixel changed while stalled");

    // page and bit must agree with the row
    a_page_bit: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> (pix.page_index == pix.pixel_y[COORD_W-1:BIT_W]) &&
                      (pix.bit_index == pix.pixel_y[BIT_W-1:0]))
        else $error("page or bit index does not match row");

    // off-screen pixels are never emitted
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> (int'(pix.pixel_x) < SCREEN_WIDTH) &&
                      (int'(pix.pixel_y) < SCREEN_HEIGHT))
        else $error("pixel outside the screen");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !pix_valid)
        else $error("pixel valid right after reset");

endmodule

bind dda_line_rasterizer_top dlr_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_dlr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
);
